[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. Every check is sampled on the
// rising clock edge and is switched off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every edge outside reset.
`define BG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bar graph glyph encoder: assertion failed");
// Check that cond never holds at an edge outside reset.
`define BG_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bar graph glyph encoder: forbidden condition seen");
`else
`define BG_ASSERT(label, clk, rst_n, prop)
`define BG_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[rtl/core/bgge_pkg.sv]
`default_nettype none

package bgge_pkg;

    // Field widths
    localparam int VALUE_BITS     = 32;
    localparam int ROW_BITS       = 8;
    localparam int BYTES_BITS     = 32;
    localparam int LEN_BITS       = 3;
    localparam int CFG_INDEX_BITS = 2;

    // Products v*H and r*M plus headroom for the bound two rows up
    localparam int PROD_BITS = VALUE_BITS + ROW_BITS + 2;

    // Row bands looked at per column: below, here, above
    localparam int COLS      = 2;
    localparam int ROWS      = 3;
    localparam int ROW_BELOW = 0;
    localparam int ROW_HERE  = 1;
    localparam int ROW_ABOVE = 2;

    // Register reset values
    localparam logic [VALUE_BITS-1:0] FULL_SCALE_RESET   = VALUE_BITS'(65536);
    localparam logic [ROW_BITS-1:0]   GRAPH_HEIGHT_RESET = ROW_BITS'(8);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FULL_SCALE   = 2'd0,
        CFG_GRAPH_HEIGHT = 2'd1,
        CFG_STYLE_SELECT = 2'd2
    } cfg_index_t;

    typedef enum logic {
        STYLE_DOTS = 1'b0,
        STYLE_FILL = 1'b1
    } style_t;

    typedef struct packed {
        logic [ROW_BITS-1:0]   row_index;
        logic                  column_odd;
        logic [VALUE_BITS-1:0] value_here;
        logic [VALUE_BITS-1:0] value_next;
        logic                  next_present;
    } request_t;

    typedef struct packed {
        logic [BYTES_BITS-1:0] glyph_bytes;
        logic [LEN_BITS-1:0]   glyph_length;
    } result_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] full_scale;
        logic [VALUE_BITS+1:0] full_scale_x3;
        logic [ROW_BITS-1:0]   graph_height;
        style_t                style_select;
    } cfg_t;

    // Per-item control that travels beside the datapath
    typedef struct packed {
        logic column_odd;
        logic next_present;
        logic row_above_ok;
        logic row_below_ok;
    } item_ctl_t;

    // Position of a value inside one row band
    typedef struct packed {
        logic                  zero;
        logic                  full;
        logic [VALUE_BITS-1:0] frac;
    } band_t;

    typedef band_t     [ROWS-1:0] band_col_t;
    typedef band_col_t [COLS-1:0] band_set_t;

endpackage

`default_nettype wire

[rtl/core/bgge_cfg.sv]
`default_nettype none

module bgge_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bgge_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bgge_pkg::VALUE_BITS-1:0]      cfg_data,
    output bgge_pkg::cfg_t                       cfg
);

    localparam int VW = bgge_pkg::VALUE_BITS;
    localparam int RW = bgge_pkg::ROW_BITS;

    logic [VW-1:0]    full_scale_reg, full_scale_next;
    logic [VW+1:0]    full_scale_x3_reg, full_scale_x3_next;
    logic [RW-1:0]    graph_height_reg, graph_height_next;
    bgge_pkg::style_t style_reg, style_next;

    // Writes go straight into the registers, so the port never stalls
    assign cfg_ready = 1'b1;

    // Decode the write beat; unknown indexes are dropped
    always_comb
    begin
        full_scale_next    = full_scale_reg;
        full_scale_x3_next = full_scale_x3_reg;
        graph_height_next  = graph_height_reg;
        style_next         = style_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bgge_pkg::CFG_FULL_SCALE:
                begin
                    full_scale_next    = cfg_data;
                    full_scale_x3_next = {2'b00, cfg_data} + {1'b0, cfg_data, 1'b0};
                end
                bgge_pkg::CFG_GRAPH_HEIGHT:
                    graph_height_next = cfg_data[RW-1:0];
                bgge_pkg::CFG_STYLE_SELECT:
                    style_next = bgge_pkg::style_t'(cfg_data[0]);
                default:
                    style_next = style_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg    <= bgge_pkg::FULL_SCALE_RESET;
            full_scale_x3_reg <= {2'b00, bgge_pkg::FULL_SCALE_RESET}
                               + {1'b0, bgge_pkg::FULL_SCALE_RESET, 1'b0};
            graph_height_reg  <= bgge_pkg::GRAPH_HEIGHT_RESET;
            style_reg         <= bgge_pkg::STYLE_DOTS;
        end
        else
        begin
            full_scale_reg    <= full_scale_next;
            full_scale_x3_reg <= full_scale_x3_next;
            graph_height_reg  <= graph_height_next;
            style_reg         <= style_next;
        end
    end

    assign cfg.full_scale    = full_scale_reg;
    assign cfg.full_scale_x3 = full_scale_x3_reg;
    assign cfg.graph_height  = graph_height_reg;
    assign cfg.style_select  = style_reg;

endmodule

`default_nettype wire

[rtl/core/bgge_band.sv]
`default_nettype none

// Place both column values inside the row bands below, at and above the
// current row: products, then band bounds, then compares.
module bgge_band (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  bgge_pkg::request_t      req,
    input  bgge_pkg::cfg_t          cfg,
    output logic                    valid_out,
    output bgge_pkg::item_ctl_t     ctl_out,
    output bgge_pkg::band_set_t     bands_out
);

    localparam int PW     = bgge_pkg::PROD_BITS;
    localparam int VW     = bgge_pkg::VALUE_BITS;
    localparam int RW     = bgge_pkg::ROW_BITS;
    localparam int COLS   = bgge_pkg::COLS;
    localparam int ROWS   = bgge_pkg::ROWS;
    localparam int BOUNDS = ROWS + 1;

    // Product stage
    logic                    p_valid_reg, p_valid_next;
    bgge_pkg::item_ctl_t     p_ctl_reg, p_ctl_next;
    logic [COLS-1:0][PW-1:0] p_prod_reg, p_prod_next;
    logic [PW-1:0]           p_rowm_reg, p_rowm_next;

    // Bound stage
    logic                      q_valid_reg, q_valid_next;
    bgge_pkg::item_ctl_t       q_ctl_reg, q_ctl_next;
    logic [COLS-1:0][PW-1:0]   q_prod_reg, q_prod_next;
    logic [BOUNDS-1:0][PW-1:0] q_bound_reg, q_bound_next;

    // Compare stage
    logic                s_valid_reg, s_valid_next;
    bgge_pkg::item_ctl_t s_ctl_reg, s_ctl_next;
    bgge_pkg::band_set_t s_band_reg, s_band_next;

    logic [PW-1:0] scale_ext;

    assign scale_ext = PW'(cfg.full_scale);

    // Scale values by height and the row by full scale
    always_comb
    begin
        p_valid_next            = valid_in;
        p_ctl_next.column_odd   = req.column_odd;
        p_ctl_next.next_present = req.next_present;
        p_ctl_next.row_above_ok = ({1'b0, req.row_index} + (RW+1)'(1))
                                < {1'b0, cfg.graph_height};
        p_ctl_next.row_below_ok = (req.row_index != '0);
        p_prod_next[0]          = PW'(req.value_here) * PW'(cfg.graph_height);
        p_prod_next[1]          = PW'(req.value_next) * PW'(cfg.graph_height);
        p_rowm_next             = PW'(req.row_index) * scale_ext;
    end

    // Form the band edges from one row below to two rows above
    always_comb
    begin
        q_valid_next    = p_valid_reg;
        q_ctl_next      = p_ctl_reg;
        q_prod_next     = p_prod_reg;
        q_bound_next[0] = p_rowm_reg - scale_ext;
        q_bound_next[1] = p_rowm_reg;
        q_bound_next[2] = p_rowm_reg + scale_ext;
        q_bound_next[3] = p_rowm_reg + (scale_ext << 1);
    end

    // Compare each value against each band
    always_comb
    begin
        s_valid_next = q_valid_reg;
        s_ctl_next   = q_ctl_reg;
        for (int c = 0; c < COLS; c++)
        begin
            for (int j = 0; j < ROWS; j++)
            begin
                s_band_next[c][j].zero = (q_prod_reg[c] <= q_bound_reg[j]);
                s_band_next[c][j].full = (q_prod_reg[c] >= q_bound_reg[j+1]);
                s_band_next[c][j].frac = VW'(q_prod_reg[c] - q_bound_reg[j]);
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            q_valid_reg <= q_valid_next;
            s_valid_reg <= s_valid_next;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        p_ctl_reg   <= p_ctl_next;
        p_prod_reg  <= p_prod_next;
        p_rowm_reg  <= p_rowm_next;
        q_ctl_reg   <= q_ctl_next;
        q_prod_reg  <= q_prod_next;
        q_bound_reg <= q_bound_next;
        s_ctl_reg   <= s_ctl_next;
        s_band_reg  <= s_band_next;
    end

    assign valid_out = s_valid_reg;
    assign ctl_out   = s_ctl_reg;
    assign bands_out = s_band_reg;

endmodule

`default_nettype wire

[rtl/core/bgge_glyph.sv]
`default_nettype none

// Turn band positions into levels, pick the glyph and encode it as UTF-8.
module bgge_glyph (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  bgge_pkg::item_ctl_t     ctl,
    input  bgge_pkg::band_set_t     bands,
    input  bgge_pkg::cfg_t          cfg,
    output logic                    done,
    output bgge_pkg::result_t       result
);

    localparam int VW = bgge_pkg::VALUE_BITS;
    localparam int CPW = 21;

    localparam logic [7:0] BRAILLE_PAGE = 8'h28;
    localparam logic [2:0] DOTS_TWO     = 3'h4;
    localparam logic [2:0] DOTS_THREE   = 3'h6;
    localparam logic [2:0] DOTS_FOUR    = 3'h7;
    localparam logic [7:0] UTF8_LEAD2   = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3   = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4   = 8'hF0;
    localparam logic [7:0] UTF8_CONT    = 8'h80;
    localparam logic [7:0] UTF8_PAYLOAD = 8'h3F;

    // Five-level quantizer for dots mode
    function automatic logic [2:0] level_dots(
        input bgge_pkg::band_t b,
        input logic [VW-1:0]   m,
        input logic [VW+1:0]   m3
    );
        logic [VW+1:0] f4;
        logic [VW+1:0] f2;
        logic [VW+1:0] m1;
        f4 = {b.frac, 2'b00};
        f2 = {1'b0, b.frac, 1'b0};
        m1 = {2'b00, m};
        if (b.zero)
            return 3'd0;
        else if (b.full)
            return 3'd4;
        else if (f4 >= m3)
            return 3'd3;
        else if (f2 >= m1)
            return 3'd2;
        else if (f4 >= m1)
            return 3'd1;
        else
            return 3'd0;
    endfunction

    // Four-level quantizer for fill mode
    function automatic logic [1:0] level_fill(
        input bgge_pkg::band_t b,
        input logic [VW-1:0]   m
    );
        logic [VW+1:0] f3;
        logic [VW+1:0] m1;
        logic [VW+1:0] m2;
        f3 = {2'b00, b.frac} + {1'b0, b.frac, 1'b0};
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        if (b.zero)
            return 2'd0;
        else if (b.full)
            return 2'd3;
        else if (f3 >= m2)
            return 2'd2;
        else if (f3 >= m1)
            return 2'd1;
        else
            return 2'd0;
    endfunction

    // Dot pattern of one Braille half column
    function automatic logic [2:0] dot_fill(input logic [2:0] lvl);
        unique case (lvl)
            3'd0, 3'd1: return 3'd0;
            3'd2:       return DOTS_TWO;
            3'd3:       return DOTS_THREE;
            default:    return DOTS_FOUR;
        endcase
    endfunction

    function automatic logic [CPW-1:0] braille_code(
        input logic [2:0] l1,
        input logic [2:0] l2
    );
        logic [7:0] dots;
        dots = {(l2 != 3'd0), (l1 != 3'd0), dot_fill(l2), dot_fill(l1)};
        return {5'b00000, BRAILLE_PAGE, dots};
    endfunction

    function automatic logic [CPW-1:0] tab_main(input logic [1:0] r, input logic [1:0] c);
        unique case ({r, c})
            4'h0:    return 21'h00020;
            4'h1:    return 21'h1FB3D;
            4'h2:    return 21'h1FB3F;
            4'h3:    return 21'h1FB9F;
            4'h4:    return 21'h1FB48;
            4'h5:    return 21'h02583;
            4'h6:    return 21'h1FB51;
            4'h7:    return 21'h1FB4F;
            4'h8:    return 21'h1FB4A;
            4'h9:    return 21'h1FB46;
            4'hA:    return 21'h02586;
            4'hB:    return 21'h1FB4D;
            4'hC:    return 21'h1FB9E;
            4'hD:    return 21'h1FB44;
            4'hE:    return 21'h1FB42;
            default: return 21'h02588;
        endcase
    endfunction

    function automatic logic [CPW-1:0] tab_high(input logic [1:0] r, input logic [1:0] c);
        unique case ({r, c})
            4'h3:    return 21'h0258C;
            4'h7:    return 21'h1FB4E;
            4'hB:    return 21'h1FB4C;
            4'hC:    return 21'h02590;
            4'hD:    return 21'h1FB43;
            4'hE:    return 21'h1FB41;
            4'hF:    return 21'h02588;
            default: return 21'h00000;
        endcase
    endfunction

    function automatic logic [CPW-1:0] tab_low(input logic [1:0] r, input logic [1:0] c);
        unique case ({r, c})
            4'h0:    return 21'h00020;
            4'h1:    return 21'h1FB3C;
            4'h2:    return 21'h1FB3E;
            4'h3:    return 21'h1FB40;
            4'h4:    return 21'h1FB47;
            4'h8:    return 21'h1FB49;
            4'hC:    return 21'h1FB4B;
            default: return 21'h00000;
        endcase
    endfunction

    // Choose block, slope or edge glyph from the neighbor rows
    function automatic logic [CPW-1:0] slope_code(
        input logic [1:0] c1, input logic [1:0] c2,
        input logic [1:0] t1, input logic [1:0] t2,
        input logic [1:0] b1, input logic [1:0] b2
    );
        if (c1 == 2'd0 && c2 == 2'd3)
            return (t2 == 2'd0) ? tab_low(2'd3, 2'd0) : tab_high(2'd3, 2'd0);
        else if (c1 == 2'd3 && c2 == 2'd0)
            return (t1 == 2'd0) ? tab_low(2'd0, 2'd3) : tab_high(2'd0, 2'd3);
        else if (c1 == 2'd0 && b1 != 2'd3)
            return tab_low(c2, 2'd0);
        else if (c1 == 2'd3 && t1 != 2'd0)
            return tab_high(c2, 2'd3);
        else if (c2 == 2'd0 && b2 != 2'd3)
            return tab_low(2'd0, c1);
        else if (c2 == 2'd3 && t2 != 2'd0)
            return tab_high(2'd3, c1);
        else
            return tab_main(c2, c1);
    endfunction

    function automatic bgge_pkg::result_t utf8_encode(input logic [CPW-1:0] cp);
        bgge_pkg::result_t r;
        r = '0;
        priority if (cp < 21'h00080)
        begin
            r.glyph_bytes  = {24'h000000, cp[7:0]};
            r.glyph_length = 3'd1;
        end
        else if (cp < 21'h00800)
        begin
            r.glyph_bytes  = {16'h0000,
                              UTF8_CONT | {2'b00, cp[5:0]},
                              UTF8_LEAD2 | {3'b000, cp[10:6]}};
            r.glyph_length = 3'd2;
        end
        else if (cp < 21'h10000)
        begin
            r.glyph_bytes  = {8'h00,
                              UTF8_CONT | {2'b00, cp[5:0]},
                              UTF8_CONT | {2'b00, cp[11:6]},
                              UTF8_LEAD3 | {4'h0, cp[15:12]}};
            r.glyph_length = 3'd3;
        end
        else
        begin
            r.glyph_bytes  = {UTF8_CONT | (UTF8_PAYLOAD & {2'b00, cp[5:0]}),
                              UTF8_CONT | {2'b00, cp[11:6]},
                              UTF8_CONT | {2'b00, cp[17:12]},
                              UTF8_LEAD4 | {5'b00000, cp[20:18]}};
            r.glyph_length = 3'd4;
        end
        return r;
    endfunction

    logic              done_reg, done_next;
    bgge_pkg::result_t result_reg, result_next;

    logic [2:0] dot_l1, dot_l2;
    logic [1:0] c1, c2, t1, t2, b1, b2;

    // Quantize both columns for both modes
    always_comb
    begin
        dot_l1 = level_dots(bands[0][bgge_pkg::ROW_HERE], cfg.full_scale, cfg.full_scale_x3);
        dot_l2 = ctl.next_present
               ? level_dots(bands[1][bgge_pkg::ROW_HERE], cfg.full_scale,
                            cfg.full_scale_x3)
               : 3'd0;
        c1 = level_fill(bands[0][bgge_pkg::ROW_HERE], cfg.full_scale);
        c2 = ctl.next_present ? level_fill(bands[1][bgge_pkg::ROW_HERE], cfg.full_scale)
                              : 2'd0;
        t1 = ctl.row_above_ok ? level_fill(bands[0][bgge_pkg::ROW_ABOVE], cfg.full_scale)
                              : 2'd0;
        t2 = (ctl.row_above_ok && ctl.next_present)
           ? level_fill(bands[1][bgge_pkg::ROW_ABOVE], cfg.full_scale) : 2'd0;
        b1 = ctl.row_below_ok ? level_fill(bands[0][bgge_pkg::ROW_BELOW], cfg.full_scale)
                              : 2'd0;
        b2 = (ctl.row_below_ok && ctl.next_present)
           ? level_fill(bands[1][bgge_pkg::ROW_BELOW], cfg.full_scale) : 2'd0;
    end

    // Select the glyph; odd columns in dots mode stay empty
    always_comb
    begin
        done_next = valid_in;
        if (cfg.style_select == bgge_pkg::STYLE_FILL)
            result_next = utf8_encode(slope_code(c1, c2, t1, t2, b1, b2));
        else if (ctl.column_odd)
            result_next = '0;
        else
            result_next = utf8_encode(braille_code(dot_l1, dot_l2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/core/bar_graph_glyph_encoder.sv]
`default_nettype none
`include "assert_macros.svh"

// Bar chart glyph encoder: one text cell of a bar chart in, its glyph out.
//
// Request channel: a beat is taken at each rising edge with start high and
// busy low. busy never rises, so a new cell may be sent every cycle.
// Result channel: done pulses for one cycle with the glyph on result. The
// receiver cannot stall it; results come out in request order, one per cell.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high and a write takes effect at its edge. Write only while no cell
// is in flight.
// Timing: a request passes from the input register through the multiply
// stage, the band bound stage, the compare stage and the glyph table with
// the UTF-8 encode into the result register, which done marks valid. One
// cell is finished per cycle.
// Reset: all valid bits clear, so no result is pending; the registers return
// to full scale 1.0, eight rows and dots mode.
module bar_graph_glyph_encoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  bgge_pkg::request_t                  request,
    output logic                                done,
    output bgge_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bgge_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bgge_pkg::VALUE_BITS-1:0]     cfg_data
);

    bgge_pkg::cfg_t      cfg;
    logic                in_valid_reg, in_valid_next;
    bgge_pkg::request_t  in_req_reg, in_req_next;
    logic                band_valid;
    bgge_pkg::item_ctl_t band_ctl;
    bgge_pkg::band_set_t band_set;

    // Fully pipelined: every cycle takes a beat
    assign busy = 1'b0;

    bgge_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Capture the request beat
    always_comb
    begin
        in_valid_next = start && !busy;
        in_req_next   = request;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        in_req_reg <= in_req_next;
    end

    bgge_band u_band (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid_reg),
        .req       (in_req_reg),
        .cfg       (cfg),
        .valid_out (band_valid),
        .ctl_out   (band_ctl),
        .bands_out (band_set)
    );

    bgge_glyph u_glyph (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (band_valid),
        .ctl      (band_ctl),
        .bands    (band_set),
        .cfg      (cfg),
        .done     (done),
        .result   (result)
    );

    // Every accepted cell yields exactly one result
    `BG_ASSERT(a_result_follows, clk, rst_n, (start && !busy) |-> ##5 done)
    `BG_ASSERT(a_result_has_cause, clk, rst_n, done |-> $past(start && !busy, 5))
    // An empty cell carries no bytes
    `BG_ASSERT(a_empty_is_zero, clk, rst_n, (done && result.glyph_length == 3'd0) |-> (result.glyph_bytes == 32'd0))
    // Glyphs are a space, a BMP block or Braille glyph or a supplementary one
    `BG_ASSERT_NEVER(a_bad_length, clk, rst_n, done && (result.glyph_length == 3'd2 || result.glyph_length > 3'd4))

endmodule

`default_nettype wire
